>>> src/c8_pkg.sv
// Shared constants, codes and control/status structs for the CHIP-8 core.
// Used by the controller, datapath and top level.
package c8_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int ADDR_W        = 12;
    localparam int STACK_DEPTH   = 16;
    localparam int SP_W          = $clog2(STACK_DEPTH);
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
    localparam int COL_W         = $clog2(SCREEN_WIDTH);

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_EXEC   = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] CFG_PROG_START   = 2'd0;
    localparam logic [1:0] CFG_FONT_BASE    = 2'd1;
    localparam logic [1:0] CFG_TIMER_RELOAD = 2'd2;
    localparam logic [1:0] CFG_UNUSED       = 2'd3;

    localparam logic [11:0] PROG_START_RST   = 12'h200;
    localparam logic [11:0] FONT_BASE_RST    = 12'h050;
    localparam logic [7:0]  TIMER_RELOAD_RST = 8'd60;

    localparam logic [2:0] CLS_SIMPLE = 3'd0;
    localparam logic [2:0] CLS_DRAW   = 3'd1;
    localparam logic [2:0] CLS_BCD    = 3'd2;
    localparam logic [2:0] CLS_DUMP   = 3'd3;
    localparam logic [2:0] CLS_LOAD   = 3'd4;
    localparam logic [2:0] CLS_BAD    = 3'd5;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic fetch0;
        logic fetch1;
        logic fetch2;
        logic rd_x;
        logic rd_y;
        logic exec;
        logic draw_a;
        logic draw_b;
        logic bcd;
        logic dump;
        logic load_a;
        logic load_b;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic       halted;
        logic [2:0] op_class;
        logic       clear_last;
        logic       cnt_last;
        logic       draw_done;
        logic       out_free;
    } sts_t;

endpackage

>>> src/c8_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/c8_ctrl.sv
// Controller state machine: sequences clear, fetch, execute and result phases.
// Depends on c8_pkg.
module c8_ctrl
    import c8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] action,
    input  sts_t       sts,
    output logic       in_stall,
    output cmd_t       cmd
);
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_F0     = 4'd2;
    localparam logic [3:0] S_F1     = 4'd3;
    localparam logic [3:0] S_F2     = 4'd4;
    localparam logic [3:0] S_RX     = 4'd5;
    localparam logic [3:0] S_RY     = 4'd6;
    localparam logic [3:0] S_EX     = 4'd7;
    localparam logic [3:0] S_DRAW_A = 4'd8;
    localparam logic [3:0] S_DRAW_B = 4'd9;
    localparam logic [3:0] S_BCD    = 4'd10;
    localparam logic [3:0] S_DUMP   = 4'd11;
    localparam logic [3:0] S_LOAD_A = 4'd12;
    localparam logic [3:0] S_LOAD_B = 4'd13;
    localparam logic [3:0] S_DONE   = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       take;

    assign take     = (state_reg == S_IDLE) && sts.out_free && in_valid;
    assign in_stall = !((state_reg == S_IDLE) && sts.out_free);

    always_comb
    begin
        cmd          = '0;
        cmd.clear_wr = (state_reg == S_CLEAR);
        cmd.accept   = take;
        cmd.fetch0   = (state_reg == S_F0);
        cmd.fetch1   = (state_reg == S_F1);
        cmd.fetch2   = (state_reg == S_F2);
        cmd.rd_x     = (state_reg == S_RX);
        cmd.rd_y     = (state_reg == S_RY);
        cmd.exec     = (state_reg == S_EX);
        cmd.draw_a   = (state_reg == S_DRAW_A);
        cmd.draw_b   = (state_reg == S_DRAW_B);
        cmd.bcd      = (state_reg == S_BCD);
        cmd.dump     = (state_reg == S_DUMP);
        cmd.load_a   = (state_reg == S_LOAD_A);
        cmd.load_b   = (state_reg == S_LOAD_B);
        cmd.finish   = (state_reg == S_DONE);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (sts.clear_last) state_next = S_IDLE;
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = (action == ACT_EXEC && !sts.halted) ? S_F0 : S_DONE;
                end
            end
            S_F0:     state_next = S_F1;
            S_F1:     state_next = S_F2;
            S_F2:     state_next = S_RX;
            S_RX:     state_next = S_RY;
            S_RY:     state_next = S_EX;
            S_EX:
            begin
                case (sts.op_class)
                    CLS_DRAW: state_next = S_DRAW_A;
                    CLS_BCD:  state_next = S_BCD;
                    CLS_DUMP: state_next = S_DUMP;
                    CLS_LOAD: state_next = S_LOAD_A;
                    default:  state_next = S_DONE;
                endcase
            end
            S_DRAW_A: state_next = sts.draw_done ? S_DONE : S_DRAW_B;
            S_DRAW_B: state_next = S_DRAW_A;
            S_BCD:    if (sts.cnt_last) state_next = S_DONE;
            S_DUMP:   if (sts.cnt_last) state_next = S_DONE;
            S_LOAD_A: state_next = S_LOAD_B;
            S_LOAD_B: state_next = sts.cnt_last ? S_DONE : S_LOAD_A;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

>>> src/c8_dp.sv
// Datapath: program memory, registers, stack, timer, framebuffer, result register.
// Depends on c8_pkg and c8_ram.
module c8_dp
    import c8_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    output sts_t         sts,
    input  logic [1:0]   action,
    input  logic [11:0]  mem_address,
    input  logic [7:0]   mem_data,
    input  logic [4:0]   display_row,
    input  logic [15:0]  keys_down,
    input  logic [7:0]   random_byte,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [11:0]  cfg_data,
    input  logic         out_stall,
    output logic         out_valid,
    output logic         status,
    output logic [11:0]  program_counter,
    output logic [15:0]  opcode,
    output logic         draw_request,
    output logic [63:0]  row_pixels
);
    logic [11:0] prog_start_reg, font_base_reg;
    logic [7:0]  reload_reg, timer_reg;
    logic [11:0] pc_reg;
    logic [15:0] i_reg;
    logic [SP_W-1:0] sp_reg;
    logic        halted_reg;
    logic [7:0]  regs_reg [16];
    logic [11:0] stack_reg [STACK_DEPTH];
    logic [63:0] fb_reg [SCREEN_HEIGHT];

    logic [1:0]  act_reg;
    logic [ROW_W-1:0] row_sel_reg;
    logic [15:0] keys_reg;
    logic [7:0]  rnd_reg;
    logic [7:0]  op_hi_reg;
    logic [15:0] op_reg;
    logic [7:0]  vx_reg, vy_reg;
    logic [3:0]  cnt_reg;
    logic        hit_reg, drew_reg;
    logic [11:0] clr_cnt_reg;

    logic        out_valid_reg, status_reg, draw_out_reg;
    logic [11:0] pc_out_reg;
    logic [15:0] op_out_reg;
    logic [63:0] row_out_reg;

    logic [3:0]  x, y, n;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [2:0]  op_class;
    logic [3:0]  reg_idx;
    logic [7:0]  reg_rd;
    logic [11:0] i_addr;
    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;
    logic [13:0] h_prod;
    logic [1:0]  dig_h;
    logic [7:0]  rem_h;
    logic [14:0] t_prod;
    logic [3:0]  dig_t, dig_o;
    logic [7:0]  digit;
    logic [COL_W-1:0] px;
    logic [ROW_W-1:0] py;
    logic [ROW_W:0]   row_sum;
    logic [ROW_W-1:0] fb_idx;
    logic [63:0] fb_rd, mask;
    logic [7:0]  t_src, timer_upd;
    logic        key_down;
    logic [SP_W-1:0] sp_inc, sp_dec;
    logic [8:0]  sum9;

    assign x   = op_reg[11:8];
    assign y   = op_reg[7:4];
    assign n   = op_reg[3:0];
    assign nn  = op_reg[7:0];
    assign nnn = op_reg[11:0];

    always_comb
    begin
        op_class = CLS_SIMPLE;
        case (op_reg[15:12])
            4'h0: if (op_reg != 16'h00E0 && op_reg != 16'h00EE) op_class = CLS_BAD;
            4'h8: if (!(n inside {[4'h0:4'h7], 4'hE})) op_class = CLS_BAD;
            4'hD: op_class = CLS_DRAW;
            4'hE: if (nn != 8'h9E && nn != 8'hA1) op_class = CLS_BAD;
            4'hF:
            begin
                case (nn)
                    8'h07, 8'h15, 8'h1E, 8'h29: op_class = CLS_SIMPLE;
                    8'h33:   op_class = CLS_BCD;
                    8'h55:   op_class = CLS_DUMP;
                    8'h65:   op_class = CLS_LOAD;
                    default: op_class = CLS_BAD;
                endcase
            end
            default: op_class = CLS_SIMPLE;
        endcase
    end

    // register file read port
    always_comb
    begin
        if (cmd.rd_y)
        begin
            reg_idx = (op_reg[15:12] == 4'hB) ? 4'h0 : y;
        end
        else if (cmd.dump)
        begin
            reg_idx = cnt_reg;
        end
        else
        begin
            reg_idx = x;
        end
    end
    assign reg_rd = regs_reg[reg_idx];

    // decimal digits by reciprocal multiply
    assign h_prod = 14'(vx_reg) * 14'd41;
    assign dig_h  = h_prod[13:12];
    assign rem_h  = vx_reg - 8'(dig_h) * 8'd100;
    assign t_prod = 15'(rem_h) * 15'd205;
    assign dig_t  = t_prod[14:11];
    assign dig_o  = 4'(rem_h - 8'(dig_t) * 8'd10);
    always_comb
    begin
        case (cnt_reg)
            4'd0:    digit = 8'(dig_h);
            4'd1:    digit = 8'(dig_t);
            default: digit = 8'(dig_o);
        endcase
    end

    assign i_addr = i_reg[11:0] + 12'(cnt_reg);

    assign mem_we = cmd.clear_wr || (cmd.accept && action == ACT_WRITE) || cmd.bcd || cmd.dump;
    always_comb
    begin
        if (cmd.clear_wr)
        begin
            mem_waddr = clr_cnt_reg;
            mem_wdata = 8'd0;
        end
        else if (cmd.accept)
        begin
            mem_waddr = mem_address;
            mem_wdata = mem_data;
        end
        else
        begin
            mem_waddr = i_addr;
            mem_wdata = cmd.bcd ? digit : reg_rd;
        end
    end
    always_comb
    begin
        if (cmd.fetch0)
        begin
            mem_raddr = pc_reg;
        end
        else if (cmd.fetch1)
        begin
            mem_raddr = pc_reg + 12'd1;
        end
        else
        begin
            mem_raddr = i_addr;
        end
    end

    c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sprite row
    assign px      = vx_reg[COL_W-1:0];
    assign py      = vy_reg[ROW_W-1:0];
    assign row_sum = {1'b0, py} + (ROW_W+1)'(cnt_reg);
    assign fb_idx  = cmd.finish ? row_sel_reg : row_sum[ROW_W-1:0];
    assign fb_rd   = fb_reg[fb_idx];
    assign mask    = {mem_rdata, 56'd0} >> px;

    assign t_src     = (op_reg[15:12] == 4'hF && nn == 8'h15) ? vx_reg : timer_reg;
    assign timer_upd = (t_src == 8'd0) ? reload_reg : t_src - 8'd1;
    assign key_down  = (vx_reg[7:4] == 4'd0) && keys_reg[vx_reg[3:0]];
    assign sp_inc    = (sp_reg == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec    = (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - 1'b1;
    assign sum9      = {1'b0, vx_reg} + {1'b0, vy_reg};

    assign sts.halted     = halted_reg;
    assign sts.op_class   = op_class;
    assign sts.clear_last = (clr_cnt_reg == 12'(MEM_BYTES - 1));
    assign sts.cnt_last   = (op_class == CLS_BCD) ? (cnt_reg == 4'd2) : (cnt_reg == x);
    assign sts.draw_done  = (cnt_reg >= n) || (row_sum >= (ROW_W+1)'(SCREEN_HEIGHT));
    assign sts.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_start_reg <= PROG_START_RST;
            font_base_reg  <= FONT_BASE_RST;
            reload_reg     <= TIMER_RELOAD_RST;
            timer_reg      <= TIMER_RELOAD_RST;
            pc_reg         <= PROG_START_RST;
            i_reg          <= '0;
            sp_reg         <= '0;
            halted_reg     <= 1'b0;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < 16; k++)
            begin
                regs_reg[k] <= '0;
            end
            for (int k = 0; k < STACK_DEPTH; k++)
            begin
                stack_reg[k] <= '0;
            end
            for (int k = 0; k < SCREEN_HEIGHT; k++)
            begin
                fb_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PROG_START:
                    begin
                        prog_start_reg <= cfg_data;
                        pc_reg         <= cfg_data;
                    end
                    CFG_FONT_BASE:    font_base_reg <= cfg_data;
                    CFG_TIMER_RELOAD: reload_reg    <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 12'd1;
            end

            if (cmd.fetch2)
            begin
                pc_reg  <= pc_reg + 12'd2;
                cnt_reg <= '0;
                hit_reg <= 1'b0;
            end

            if (cmd.exec)
            begin
                if (op_class == CLS_BAD)
                begin
                    halted_reg <= 1'b1;
                end
                else
                begin
                    timer_reg <= timer_upd;
                end
                case (op_reg[15:12])
                    4'h0:
                    begin
                        if (op_reg == 16'h00E0)
                        begin
                            for (int k = 0; k < SCREEN_HEIGHT; k++)
                            begin
                                fb_reg[k] <= '0;
                            end
                        end
                        else if (op_reg == 16'h00EE)
                        begin
                            sp_reg <= sp_dec;
                            pc_reg <= stack_reg[sp_dec];
                        end
                    end
                    4'h1: pc_reg <= nnn;
                    4'h2:
                    begin
                        stack_reg[sp_reg] <= pc_reg;
                        sp_reg <= sp_inc;
                        pc_reg <= nnn;
                    end
                    4'h3: if (vx_reg == nn) pc_reg <= pc_reg + 12'd2;
                    4'h4: if (vx_reg != nn) pc_reg <= pc_reg + 12'd2;
                    4'h5: if (vx_reg == vy_reg) pc_reg <= pc_reg + 12'd2;
                    4'h6: regs_reg[x] <= nn;
                    4'h7: regs_reg[x] <= vx_reg + nn;
                    4'h8:
                    begin
                        case (n)
                            4'h0: regs_reg[x] <= vy_reg;
                            4'h1: regs_reg[x] <= vx_reg | vy_reg;
                            4'h2: regs_reg[x] <= vx_reg & vy_reg;
                            4'h3: regs_reg[x] <= vx_reg ^ vy_reg;
                            4'h4:
                            begin
                                regs_reg[x]  <= sum9[7:0];
                                regs_reg[15] <= {7'd0, sum9[8]};
                            end
                            4'h5:
                            begin
                                regs_reg[x]  <= vx_reg - vy_reg;
                                regs_reg[15] <= {7'd0, vx_reg >= vy_reg};
                            end
                            4'h6:
                            begin
                                regs_reg[15] <= {7'd0, vx_reg[0]};
                                regs_reg[x]  <= vx_reg >> 1;
                            end
                            4'h7:
                            begin
                                regs_reg[x]  <= vy_reg - vx_reg;
                                regs_reg[15] <= {7'd0, vy_reg >= vx_reg};
                            end
                            4'hE:
                            begin
                                regs_reg[15] <= {7'd0, vx_reg[7]};
                                regs_reg[x]  <= vx_reg << 1;
                            end
                            default: ;
                        endcase
                    end
                    4'h9: if (vx_reg != vy_reg) pc_reg <= pc_reg + 12'd2;
                    4'hA: i_reg <= {4'd0, nnn};
                    4'hB: pc_reg <= nnn + {4'd0, vy_reg};
                    4'hC: regs_reg[x] <= rnd_reg & nn;
                    4'hE:
                    begin
                        if ((nn == 8'h9E && key_down) || (nn == 8'hA1 && !key_down))
                        begin
                            pc_reg <= pc_reg + 12'd2;
                        end
                    end
                    4'hF:
                    begin
                        case (nn)
                            8'h07: regs_reg[x] <= timer_reg;
                            8'h1E: i_reg <= i_reg + {8'd0, vx_reg};
                            8'h29: i_reg <= {4'd0, font_base_reg} + 16'(vx_reg) * 16'd5;
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end

            if (cmd.draw_a && sts.draw_done)
            begin
                regs_reg[15] <= {7'd0, hit_reg};
            end
            if (cmd.draw_b)
            begin
                fb_reg[fb_idx] <= fb_rd ^ mask;
                if ((fb_rd & mask) != '0)
                begin
                    hit_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 4'd1;
            end
            if (cmd.bcd || cmd.dump)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
            if (cmd.load_b)
            begin
                regs_reg[cnt_reg] <= mem_rdata;
                cnt_reg <= cnt_reg + 4'd1;
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg     <= action;
            row_sel_reg <= display_row;
            keys_reg    <= keys_down;
            rnd_reg     <= random_byte;
            op_reg      <= '0;
            drew_reg    <= 1'b0;
        end
        if (cmd.fetch1)
        begin
            op_hi_reg <= mem_rdata;
        end
        if (cmd.fetch2)
        begin
            op_reg <= {op_hi_reg, mem_rdata};
        end
        if (cmd.rd_x)
        begin
            vx_reg <= reg_rd;
        end
        if (cmd.rd_y)
        begin
            vy_reg <= reg_rd;
        end
        if (cmd.exec && (op_reg == 16'h00E0 || op_class == CLS_DRAW))
        begin
            drew_reg <= 1'b1;
        end
        if (cmd.finish)
        begin
            status_reg   <= halted_reg;
            pc_out_reg   <= pc_reg;
            op_out_reg   <= op_reg;
            draw_out_reg <= drew_reg;
            row_out_reg  <= (act_reg == ACT_READ) ? fb_rd : 64'd0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign program_counter = pc_out_reg;
    assign opcode          = op_out_reg;
    assign draw_request    = draw_out_reg;
    assign row_pixels      = row_out_reg;
endmodule

>>> src/chip8_instruction_core_top.sv
// CHIP-8 instruction core. One request writes a memory byte, executes one
// instruction, or reads one 64-pixel framebuffer row; each gives one result.
// Timing: after reset a clearing pass writes zero through the 4096-byte
// program memory, one byte per cycle; no request is taken until it ends.
// Configuration writes are taken at any time. A write or row read then goes
// straight to its result; an instruction is fetched a byte at a time, reads
// VX and VY, executes, and for DXYN, FX33, FX55 and FX65 then steps through
// sprite rows, digits or registers before its result. The next request is
// taken once the previous result has been taken.
// Depends on c8_pkg, c8_ctrl, c8_dp.
module chip8_instruction_core_top
    import c8_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   action,
    input  logic [11:0]  mem_address,
    input  logic [7:0]   mem_data,
    input  logic [4:0]   display_row,
    input  logic [15:0]  keys_down,
    input  logic [7:0]   random_byte,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         status,
    output logic [11:0]  program_counter,
    output logic [15:0]  opcode,
    output logic         draw_request,
    output logic [63:0]  row_pixels,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [11:0]  cfg_data
);
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    c8_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    c8_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .action          (action),
        .mem_address     (mem_address),
        .mem_data        (mem_data),
        .display_row     (display_row),
        .keys_down       (keys_down),
        .random_byte     (random_byte),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .status          (status),
        .program_counter (program_counter),
        .opcode          (opcode),
        .draw_request    (draw_request),
        .row_pixels      (row_pixels)
    );
endmodule

>>> src/c8_checker.sv
// Port-level checks for the CHIP-8 core, bound to the top level.
// Depends on chip8_instruction_core_top.
module c8_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         in_valid,
    input logic         in_stall,
    input logic         out_valid,
    input logic         out_stall,
    input logic         status,
    input logic [11:0]  program_counter,
    input logic [15:0]  opcode,
    input logic         draw_request,
    input logic [63:0]  row_pixels
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(program_counter) && $stable(row_pixels))
        else $error("stalled result changed");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result shown before request was processed");

    a_draw_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && draw_request |-> !status && opcode != 16'd0 && row_pixels == 64'd0)
        else $error("draw flag on a halted or non-execute result");
endmodule

bind chip8_instruction_core_top c8_checker u_chk (.*);
